// File: hw/rtl/scatr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatr_pkg: shared types, constants and tables of the ATR parser
// Holds the byte record passed from the front to the back stage, the parse
// state, the summary beat and the ISO 7816-3 decode tables.
// ----------------------------------------------------------------------------
package scatr_pkg;

  // Sizing
  localparam int unsigned MaxAtrBytes = 33;
  localparam int unsigned MaxGroups   = 7;
  localparam int unsigned CntW        = 6;
  localparam int unsigned GrpW        = 4;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QPtrW       = 1;

  // TS codes
  localparam logic [7:0] TsInverseRaw = 8'h03;
  localparam logic [7:0] TsDirect     = 8'h3B;
  localparam logic [7:0] TsInverse    = 8'h3F;

  // Convention codes
  typedef enum logic [1:0] {
    CONV_DIRECT  = 2'd0,
    CONV_INVERSE = 2'd1,
    CONV_UNKNOWN = 2'd2
  } conv_e;

  // Record of one classified byte
  typedef struct packed {
    logic [7:0]      data;
    logic [CntW-1:0] idx;
    logic [CntW-1:0] count;
    logic            drop;
    logic            last;
  } scatr_rec_t;

  // Parse state held by the back stage
  typedef struct packed {
    logic [7:0]      ts;
    logic [3:0]      pending;
    logic [GrpW-1:0] group;
    logic [CntW-1:0] iend;
    logic [3:0]      hist;
    logic [8:0]      ta1;
    logic [8:0]      tb1;
    logic [8:0]      tc1;
    logic [8:0]      tb2;
    logic            tck;
    logic            done;
    logic            err;
  } scatr_state_t;

  // Summary beat
  typedef struct packed {
    logic        status;
    logic [1:0]  convention;
    logic [3:0]  protocol_count;
    logic [11:0] clock_factor_f;
    logic [3:0]  rate_index_di;
    logic [24:0] max_clock_hz;
    logic [6:0]  prog_current_ma;
    logic [7:0]  prog_voltage;
    logic [7:0]  guard_time_n;
    logic [3:0]  historical_count;
    logic        check_byte_present;
    logic [5:0]  atr_length;
  } scatr_sum_t;

  // Bit-reverse and complement for the inverse convention
  function automatic logic [7:0] flip_byte(input logic [7:0] b);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = b[k];
    end
    return ~r;
  endfunction

  // Clock rate conversion factor F
  function automatic logic [11:0] f_lookup(input logic [3:0] fi);
    logic [11:0] f;
    unique case (fi)
      4'd0, 4'd1: f = 12'd372;
      4'd2:       f = 12'd558;
      4'd3:       f = 12'd744;
      4'd4:       f = 12'd1116;
      4'd5:       f = 12'd1488;
      4'd6:       f = 12'd1860;
      4'd9:       f = 12'd512;
      4'd10:      f = 12'd768;
      4'd11:      f = 12'd1024;
      4'd12:      f = 12'd1536;
      4'd13:      f = 12'd2048;
      default:    f = 12'd0;
    endcase
    return f;
  endfunction

  // Maximum clock frequency Fs
  function automatic logic [24:0] fs_lookup(input logic [3:0] fi);
    logic [24:0] fs;
    unique case (fi)
      4'd0:        fs = 25'd4000000;
      4'd1, 4'd9:  fs = 25'd5000000;
      4'd2:        fs = 25'd6000000;
      4'd3:        fs = 25'd8000000;
      4'd4:        fs = 25'd12000000;
      4'd5:        fs = 25'd16000000;
      4'd6, 4'd13: fs = 25'd20000000;
      4'd10:       fs = 25'd7500000;
      4'd11:       fs = 25'd10000000;
      4'd12:       fs = 25'd15000000;
      default:     fs = 25'd0;
    endcase
    return fs;
  endfunction

  // Programming current I in mA
  function automatic logic [6:0] i_lookup(input logic [1:0] ii);
    logic [6:0] i;
    unique case (ii)
      2'd0:    i = 7'd25;
      2'd1:    i = 7'd50;
      2'd2:    i = 7'd100;
      default: i = 7'd0;
    endcase
    return i;
  endfunction

endpackage

// File: hw/rtl/scatr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatr_if: channel interfaces of the ATR parser
// Raw byte channel in and summary channel out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface scatr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface scatr_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [1:0]  convention;
  logic [3:0]  protocol_count;
  logic [11:0] clock_factor_f;
  logic [3:0]  rate_index_di;
  logic [24:0] max_clock_hz;
  logic [6:0]  prog_current_ma;
  logic [7:0]  prog_voltage;
  logic [7:0]  guard_time_n;
  logic [3:0]  historical_count;
  logic        check_byte_present;
  logic [5:0]  atr_length;

  modport source (
    output valid, input ready,
    output status, output convention, output protocol_count, output clock_factor_f,
    output rate_index_di, output max_clock_hz, output prog_current_ma,
    output prog_voltage, output guard_time_n, output historical_count,
    output check_byte_present, output atr_length
  );
  modport sink (
    input valid, output ready,
    input status, input convention, input protocol_count, input clock_factor_f,
    input rate_index_di, input max_clock_hz, input prog_current_ma,
    input prog_voltage, input guard_time_n, input historical_count,
    input check_byte_present, input atr_length
  );
endinterface

// File: hw/rtl/scatr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatr_front: byte intake and classification
// Counts bytes of the current ATR, detects the inverse convention on TS,
// un-flips bytes and tags each beat with its index before queueing it.
// ----------------------------------------------------------------------------
module scatr_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  scatr_in_if.sink               atr_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output scatr_pkg::scatr_rec_t  push_data_o
);
  import scatr_pkg::*;

  logic [CntW-1:0] byte_count_q, byte_count_d;
  logic            inverse_q, inverse_d;
  logic            drop;
  logic            inv_now;
  logic            push;

  assign atr_i.ready  = push_ready_i;
  assign push_valid_o = atr_i.valid;
  assign push         = atr_i.valid & push_ready_i;

  // Classify the incoming beat
  always_comb begin
    drop    = byte_count_q >= CntW'(MaxAtrBytes);
    inv_now = (byte_count_q == '0) ? (atr_i.data_byte == TsInverseRaw) : inverse_q;
    push_data_o.data  = inv_now ? flip_byte(atr_i.data_byte) : atr_i.data_byte;
    push_data_o.idx   = byte_count_q;
    push_data_o.count = drop ? byte_count_q : byte_count_q + CntW'(1);
    push_data_o.drop  = drop;
    push_data_o.last  = atr_i.last_byte;
  end

  // Advance the byte counter, restart after the final byte
  always_comb begin
    byte_count_d = byte_count_q;
    inverse_d    = inverse_q;
    if (push) begin
      if (atr_i.last_byte) begin
        byte_count_d = '0;
        inverse_d    = 1'b0;
      end else if (!drop) begin
        byte_count_d = byte_count_q + CntW'(1);
        inverse_d    = inv_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      inverse_q    <= 1'b0;
    end else begin
      byte_count_q <= byte_count_d;
      inverse_q    <= inverse_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= CntW'(MaxAtrBytes))
    else $error("byte counter ran past the ATR limit");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && atr_i.last_byte |=> byte_count_q == '0 && !inverse_q)
    else $error("counter not restarted after final byte");

endmodule

// File: hw/rtl/scatr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatr_fifo: short queue between front and back stage
// Two-entry FIFO of classified byte records.
// ----------------------------------------------------------------------------
module scatr_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_valid_i,
  output logic                   push_ready_o,
  input  scatr_pkg::scatr_rec_t  push_data_i,
  output logic                   pop_valid_o,
  input  logic                   pop_ready_i,
  output scatr_pkg::scatr_rec_t  pop_data_o
);
  import scatr_pkg::*;

  scatr_rec_t       mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   fill_q, fill_d;
  logic             push, pop;

  assign push_ready_o = fill_q != (QPtrW+1)'(QueueDepth);
  assign pop_valid_o  = fill_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // Track fill level
  always_comb begin
    fill_d = fill_q;
    case ({push, pop})
      2'b10:   fill_d = fill_q + (QPtrW+1)'(1);
      2'b01:   fill_d = fill_q - (QPtrW+1)'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (push) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
    end
  end

  // Store the beat
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (QPtrW+1)'(QueueDepth))
    else $error("queue overfilled");

endmodule

// File: hw/rtl/scatr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatr_back: interface byte parse and summary
// Follows T0 and the TDi presence nibbles, keeps TA1, TB1, TC1, TB2, and on
// the final byte builds the summary into the output register.
// ----------------------------------------------------------------------------
module scatr_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pop_valid_i,
  output logic                   pop_ready_o,
  input  scatr_pkg::scatr_rec_t  pop_data_i,
  output logic                   sum_valid_o,
  input  logic                   sum_ready_i,
  output scatr_pkg::scatr_sum_t  sum_o
);
  import scatr_pkg::*;

  scatr_state_t    st_q, st_u;
  scatr_sum_t      sum_q, sum_d;
  logic            sum_valid_q;
  logic            pop;
  logic [7:0]      b;
  logic [CntW-1:0] len_l;
  logic            mal_base, mal;
  logic [CntW:0]   rem;
  logic [CntW:0]   ptr;
  logic [3:0]      hbn;
  logic [3:0]      fi;
  logic [GrpW:0]   pc_full;

  assign b   = pop_data_i.data;
  assign pop = pop_valid_i & pop_ready_o;

  // Take a beat unless a summary would land on a full output register
  assign pop_ready_o = !pop_data_i.last || !sum_valid_q || sum_ready_i;

  // Update the parse state with one byte
  always_comb begin
    st_u = st_q;
    if (pop_data_i.drop) begin
      st_u.err = 1'b1;
    end else if (pop_data_i.idx == CntW'(0)) begin
      st_u.ts = b;
    end else if (pop_data_i.idx == CntW'(1)) begin
      st_u.pending = b[7:4];
      st_u.hist    = b[3:0];
      st_u.iend    = CntW'(1);
      if (b[7:4] == 4'd0) st_u.done = 1'b1;
    end else if (!st_q.done) begin
      if (st_q.pending[0]) begin
        if (st_q.group == '0) st_u.ta1 = {1'b1, b};
        st_u.pending[0] = 1'b0;
      end else if (st_q.pending[1]) begin
        if (st_q.group == '0) st_u.tb1 = {1'b1, b};
        else if (st_q.group == GrpW'(1)) st_u.tb2 = {1'b1, b};
        st_u.pending[1] = 1'b0;
      end else if (st_q.pending[2]) begin
        if (st_q.group == '0) st_u.tc1 = {1'b1, b};
        st_u.pending[2] = 1'b0;
      end else begin
        st_u.pending = 4'd0;
        if (st_q.group >= GrpW'(MaxGroups)) begin
          st_u.err = 1'b1;
        end else begin
          st_u.group   = st_q.group + GrpW'(1);
          st_u.tck     = b[3:0] != 4'd0;
          st_u.pending = b[7:4];
        end
      end
      st_u.iend = pop_data_i.idx;
      if (st_u.pending == 4'd0) st_u.done = 1'b1;
    end
  end

  // Build the summary from the updated state
  always_comb begin
    len_l    = pop_data_i.count;
    mal_base = st_u.err || (len_l < CntW'(2)) || !st_u.done;
    mal      = mal_base;
    rem      = {1'b0, len_l} - (CntW+1)'(1) - {1'b0, st_u.iend};
    hbn      = st_u.hist;
    if ({{(CntW-3){1'b0}}, hbn} > rem) begin
      if (rem == '0) mal = 1'b1;
      else hbn = rem[3:0] - 4'd1;
    end
    ptr = {1'b0, st_u.iend} + {{(CntW-3){1'b0}}, hbn};
    if (st_u.tck) begin
      if (ptr + (CntW+1)'(1) >= {1'b0, len_l}) mal = 1'b1;
      else ptr = ptr + (CntW+1)'(1);
    end
    if (st_u.group == '0) begin
      if (st_u.ta1[8] && fs_lookup(st_u.ta1[7:4]) == 25'd0) mal = 1'b1;
      if (st_u.tb1[8] && st_u.tb1[7:0] > 8'h80) mal = 1'b1;
    end

    fi      = st_u.ta1[8] ? st_u.ta1[7:4] : 4'd1;
    pc_full = {1'b0, st_u.group} + (GrpW+1)'(1);

    sum_d.status = mal;
    if (st_u.ts == TsDirect)       sum_d.convention = CONV_DIRECT;
    else if (st_u.ts == TsInverse) sum_d.convention = CONV_INVERSE;
    else                           sum_d.convention = CONV_UNKNOWN;
    sum_d.protocol_count  = (pc_full > (GrpW+1)'(15)) ? 4'd15 : pc_full[3:0];
    sum_d.clock_factor_f  = f_lookup(fi);
    sum_d.rate_index_di   = st_u.ta1[8] ? st_u.ta1[3:0] : 4'd1;
    sum_d.max_clock_hz    = fs_lookup(fi);
    sum_d.prog_current_ma = st_u.tb1[8] ? i_lookup(st_u.tb1[6:5]) : 7'd50;
    sum_d.prog_voltage    = st_u.tb2[8] ? st_u.tb2[7:0]
                          : (st_u.tb1[8] ? {3'b000, st_u.tb1[4:0]} : 8'd5);
    sum_d.guard_time_n       = st_u.tc1[8] ? st_u.tc1[7:0] : 8'd0;
    sum_d.historical_count   = mal ? 4'd0 : hbn;
    sum_d.check_byte_present = mal ? 1'b0 : st_u.tck;
    sum_d.atr_length         = mal ? len_l : ptr[CntW-1:0] + CntW'(1);
  end

  // Hold the parse state, clear it after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      sum_valid_q <= 1'b0;
    end else begin
      if (pop) st_q <= pop_data_i.last ? '0 : st_u;
      if (pop && pop_data_i.last) sum_valid_q <= 1'b1;
      else if (sum_ready_i)       sum_valid_q <= 1'b0;
    end
  end

  // Load the summary register
  always_ff @(posedge clk_i) begin
    if (pop && pop_data_i.last) sum_q <= sum_d;
  end

  assign sum_valid_o = sum_valid_q;
  assign sum_o       = sum_q;

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && pop_data_i.last |=> st_q == '0 && sum_valid_q)
    else $error("state not cleared or summary lost after final byte");

  a_group_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.group <= GrpW'(MaxGroups))
    else $error("group index beyond limit");

endmodule

// File: hw/rtl/smartcard_atr_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smartcard_atr_parser_unit: ISO 7816-3 answer-to-reset parser
// Front stage, two-beat queue and back stage producing one summary per ATR.
// ----------------------------------------------------------------------------
// Takes one raw ATR byte per beat on atr_i, the final byte marked by
// last_byte, and gives one summary beat on sum_o per ATR. A byte is taken
// every cycle while the queue has room; the front stage pushes it into a
// two-entry queue, from which the back stage pops and parses it. The
// summary is registered: sum_o goes valid once the back stage has loaded
// the output register from the final byte, provided it is free. The back
// stage holds a final byte in the queue while an earlier summary is still
// waiting on sum_o, so the queue fills with that final byte and one more,
// and atr_i then stalls until the waiting summary is taken.
module smartcard_atr_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  scatr_in_if.sink   atr_i,
  scatr_out_if.source sum_o
);
  import scatr_pkg::*;

  logic       push_valid, push_ready;
  scatr_rec_t push_data;
  logic       pop_valid, pop_ready;
  scatr_rec_t pop_data;
  scatr_sum_t sum;

  scatr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .atr_i        (atr_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  scatr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  scatr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .sum_valid_o (sum_o.valid),
    .sum_ready_i (sum_o.ready),
    .sum_o       (sum)
  );

  // Drive the summary fields
  assign sum_o.status             = sum.status;
  assign sum_o.convention         = sum.convention;
  assign sum_o.protocol_count     = sum.protocol_count;
  assign sum_o.clock_factor_f     = sum.clock_factor_f;
  assign sum_o.rate_index_di      = sum.rate_index_di;
  assign sum_o.max_clock_hz       = sum.max_clock_hz;
  assign sum_o.prog_current_ma    = sum.prog_current_ma;
  assign sum_o.prog_voltage       = sum.prog_voltage;
  assign sum_o.guard_time_n       = sum.guard_time_n;
  assign sum_o.historical_count   = sum.historical_count;
  assign sum_o.check_byte_present = sum.check_byte_present;
  assign sum_o.atr_length         = sum.atr_length;

endmodule

// File: tb/scatr_atr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatr_atr_checker: summary predictor and comparator for the ATR parser
// Watches the raw byte channel and the summary channel, decodes each ATR
// byte by byte into its own copy of the parse state, and compares every
// summary beat field by field with the oldest predicted summary.
// ----------------------------------------------------------------------------
module scatr_atr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  scatr_in_if         atr_mon,
  scatr_out_if        sum_mon,
  output int unsigned mismatch_count_o,
  output int unsigned summaries_due_o
);
  import scatr_pkg::*;

  // Decode state of the ATR in flight
  logic [5:0] n_taken;
  logic       inv_conv;
  logic [7:0] ts_byte;
  logic [3:0] due_mask;
  logic [3:0] td_count;
  logic [5:0] iface_last;
  logic [3:0] hist_decl;
  logic       ta1_seen, tb1_seen, tc1_seen, tb2_seen;
  logic [7:0] ta1_val, tb1_val, tc1_val, tb2_val;
  logic       tck_due;
  logic       iface_complete;
  logic       bad_seen;

  scatr_sum_t pending_summaries[$];
  scatr_sum_t want;

  // Clock rate conversion factor F at index FI
  function automatic logic [11:0] rate_factor(input logic [3:0] fi);
    logic [11:0] f;
    case (fi)
      4'd0, 4'd1: f = 12'd372;
      4'd2:       f = 12'd558;
      4'd3:       f = 12'd744;
      4'd4:       f = 12'd1116;
      4'd5:       f = 12'd1488;
      4'd6:       f = 12'd1860;
      4'd9:       f = 12'd512;
      4'd10:      f = 12'd768;
      4'd11:      f = 12'd1024;
      4'd12:      f = 12'd1536;
      4'd13:      f = 12'd2048;
      default:    f = 12'd0;
    endcase
    return f;
  endfunction

  // Maximum card clock Fs at index FI
  function automatic logic [24:0] card_clock_max(input logic [3:0] fi);
    logic [24:0] hz;
    case (fi)
      4'd0:        hz = 25'd4000000;
      4'd1, 4'd9:  hz = 25'd5000000;
      4'd2:        hz = 25'd6000000;
      4'd3:        hz = 25'd8000000;
      4'd4:        hz = 25'd12000000;
      4'd5:        hz = 25'd16000000;
      4'd6, 4'd13: hz = 25'd20000000;
      4'd10:       hz = 25'd7500000;
      4'd11:       hz = 25'd10000000;
      4'd12:       hz = 25'd15000000;
      default:     hz = 25'd0;
    endcase
    return hz;
  endfunction

  // Programming current in mA from TB1 bits 6:5
  function automatic logic [6:0] vpp_current(input logic [1:0] ii);
    logic [6:0] ma;
    case (ii)
      2'd0:    ma = 7'd25;
      2'd1:    ma = 7'd50;
      2'd2:    ma = 7'd100;
      default: ma = 7'd0;
    endcase
    return ma;
  endfunction

  task automatic clear_parse();
    n_taken        = '0;
    inv_conv       = 1'b0;
    ts_byte        = '0;
    due_mask       = '0;
    td_count       = '0;
    iface_last     = '0;
    hist_decl      = '0;
    ta1_seen       = 1'b0;
    tb1_seen       = 1'b0;
    tc1_seen       = 1'b0;
    tb2_seen       = 1'b0;
    ta1_val        = '0;
    tb1_val        = '0;
    tc1_val        = '0;
    tb2_val        = '0;
    tck_due        = 1'b0;
    iface_complete = 1'b0;
    bad_seen       = 1'b0;
  endtask

  // Fold one accepted byte into the decode state; on the final byte queue
  // the summary it must produce and start afresh
  task automatic absorb_atr_byte(input logic [7:0] raw, input logic fin);
    logic [7:0]  b;
    logic        bad;
    logic [3:0]  fi;
    int unsigned ptr, rem, hist_n, len, pc;
    scatr_sum_t  s;
    b = raw;
    if (n_taken >= MaxAtrBytes) begin
      // drop bytes beyond the size limit, and mark the ATR
      bad_seen = 1'b1;
    end else begin
      if (n_taken == 0) inv_conv = (raw == TsInverseRaw);
      if (inv_conv) begin
        for (int k = 0; k < 8; k++) b[7-k] = ~raw[k];
      end
      if (n_taken == 0) begin
        ts_byte = b;
      end else if (n_taken == 1) begin
        due_mask   = b[7:4];
        hist_decl  = b[3:0];
        iface_last = 6'd1;
        if (b[7:4] == 4'd0) iface_complete = 1'b1;
      end else if (!iface_complete) begin
        // interface bytes come in TA, TB, TC, TD order within a group
        if (due_mask[0]) begin
          if (td_count == 0) begin
            ta1_seen = 1'b1;
            ta1_val  = b;
          end
          due_mask[0] = 1'b0;
        end else if (due_mask[1]) begin
          if (td_count == 0) begin
            tb1_seen = 1'b1;
            tb1_val  = b;
          end else if (td_count == 1) begin
            tb2_seen = 1'b1;
            tb2_val  = b;
          end
          due_mask[1] = 1'b0;
        end else if (due_mask[2]) begin
          if (td_count == 0) begin
            tc1_seen = 1'b1;
            tc1_val  = b;
          end
          due_mask[2] = 1'b0;
        end else begin
          due_mask = 4'd0;
          if (td_count >= MaxGroups) begin
            bad_seen = 1'b1;
          end else begin
            td_count = td_count + 4'd1;
            tck_due  = (b[3:0] != 4'd0);
            due_mask = b[7:4];
          end
        end
        iface_last = n_taken;
        if (due_mask == 4'd0) iface_complete = 1'b1;
      end
      n_taken = n_taken + 6'd1;
    end

    if (fin) begin
      bad    = bad_seen || (n_taken < 2) || !iface_complete;
      hist_n = 0;
      len    = 0;
      if (!bad) begin
        ptr    = iface_last;
        rem    = n_taken - 1 - ptr;
        hist_n = hist_decl;
        // historical bytes cut short: keep what arrived less one
        if (hist_n > rem) begin
          if (rem == 0) bad = 1'b1;
          else hist_n = rem - 1;
        end
        ptr = ptr + hist_n;
        if (tck_due) begin
          if (ptr + 1 >= n_taken) bad = 1'b1;
          else ptr = ptr + 1;
        end
        len = ptr + 1;
        // a lone group must carry a usable FI and a sane TB1
        if (td_count == 0) begin
          if (ta1_seen && card_clock_max(ta1_val[7:4]) == 25'd0) bad = 1'b1;
          if (tb1_seen && tb1_val > 8'h80) bad = 1'b1;
        end
      end

      fi = ta1_seen ? ta1_val[7:4] : 4'd1;
      pc = td_count + 1;
      if (pc > 15) pc = 15;

      s.status             = bad;
      s.convention         = (ts_byte == TsDirect)  ? CONV_DIRECT :
                             (ts_byte == TsInverse) ? CONV_INVERSE : CONV_UNKNOWN;
      s.protocol_count     = pc[3:0];
      s.clock_factor_f     = rate_factor(fi);
      s.rate_index_di      = ta1_seen ? ta1_val[3:0] : 4'd1;
      s.max_clock_hz       = card_clock_max(fi);
      s.prog_current_ma    = tb1_seen ? vpp_current(tb1_val[6:5]) : 7'd50;
      s.prog_voltage       = tb2_seen ? tb2_val :
                             (tb1_seen ? {3'b000, tb1_val[4:0]} : 8'd5);
      s.guard_time_n       = tc1_seen ? tc1_val : 8'd0;
      s.historical_count   = bad ? 4'd0 : hist_n[3:0];
      s.check_byte_present = bad ? 1'b0 : tck_due;
      s.atr_length         = bad ? n_taken : len[5:0];
      pending_summaries.push_back(s);
      clear_parse();
    end
  endtask

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatch_count_o++;
    end
  endtask

  // Check the summary beat first, then fold in the byte beat of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      pending_summaries.delete();
      mismatch_count_o = 0;
      summaries_due_o <= 0;
    end else begin
      if (sum_mon.valid && sum_mon.ready) begin
        if (pending_summaries.size() == 0) begin
          $error("summary beat with no ATR awaiting one");
          mismatch_count_o++;
        end else begin
          want = pending_summaries.pop_front();
          compare_field("status", want.status, sum_mon.status);
          compare_field("convention", want.convention, sum_mon.convention);
          compare_field("protocol_count", want.protocol_count, sum_mon.protocol_count);
          compare_field("clock_factor_f", want.clock_factor_f, sum_mon.clock_factor_f);
          compare_field("rate_index_di", want.rate_index_di, sum_mon.rate_index_di);
          compare_field("max_clock_hz", want.max_clock_hz, sum_mon.max_clock_hz);
          compare_field("prog_current_ma", want.prog_current_ma, sum_mon.prog_current_ma);
          compare_field("prog_voltage", want.prog_voltage, sum_mon.prog_voltage);
          compare_field("guard_time_n", want.guard_time_n, sum_mon.guard_time_n);
          compare_field("historical_count", want.historical_count,
                        sum_mon.historical_count);
          compare_field("check_byte_present", want.check_byte_present,
                        sum_mon.check_byte_present);
          compare_field("atr_length", want.atr_length, sum_mon.atr_length);
        end
      end
      if (atr_mon.valid && atr_mon.ready) begin
        absorb_atr_byte(atr_mon.data_byte, atr_mon.last_byte);
      end
      summaries_due_o <= pending_summaries.size();
    end
  end

endmodule

// File: tb/tb_smartcard_atr_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smartcard_atr_parser_unit: stimulus and verdict for the ATR parser
// Sends a handful of hand-built ATRs covering the edge cases, then random
// ATRs in both conventions, with cut-off, padded, oversized and junk ones
// mixed in. Both channels idle in random bursts; a checker beside the block
// predicts every summary and counts mismatches.
// ----------------------------------------------------------------------------
module tb_smartcard_atr_parser_unit;
  import scatr_pkg::*;

  logic        clk;
  logic        rst_n;
  int unsigned mismatches;
  int unsigned summaries_due;

  // Idling controls: per-ATR burst odds in percent, and the calm tail
  int unsigned gap_pct;
  int unsigned stall_pct;
  bit          quiet;
  int unsigned bytes_sent;

  // Logical bytes of the ATR about to be sent
  logic [7:0]  atr_q[$];

  scatr_in_if  atr_if ();
  scatr_out_if sum_if ();

  smartcard_atr_parser_unit u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .atr_i  (atr_if),
    .sum_o  (sum_if)
  );

  scatr_atr_checker u_chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .atr_mon          (atr_if),
    .sum_mon          (sum_if),
    .mismatch_count_o (mismatches),
    .summaries_due_o  (summaries_due)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Summary side: drop ready in random bursts
  initial begin
    sum_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        sum_if.ready = 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk);
      end else begin
        sum_if.ready = 1'b1;
      end
    end
  end

  // Send the queued ATR one beat per byte, encoding it for the inverse
  // convention when asked, and mark the final byte
  task automatic send_atr(input bit inv);
    logic [7:0] raw;
    for (int i = 0; i < atr_q.size(); i++) begin
      raw = atr_q[i];
      if (inv) begin
        if (i == 0) raw = TsInverseRaw;
        else for (int k = 0; k < 8; k++) raw[7-k] = ~atr_q[i][k];
      end
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
        @(negedge clk);
        atr_if.valid = 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk);
      end
      @(negedge clk);
      atr_if.valid     = 1'b1;
      atr_if.data_byte = raw;
      atr_if.last_byte = (i == atr_q.size() - 1);
      @(posedge clk);
      while (!atr_if.ready) @(posedge clk);
      bytes_sent++;
    end
  endtask

  // Hold the byte channel until every summary has come out
  task automatic wait_drained();
    @(negedge clk);
    atr_if.valid = 1'b0;
    while (summaries_due != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int          n_grp, k_hist, cut, target, waited;
    logic [3:0]  mask, next_mask, proto;
    logic [7:0]  ts, ib;
    bit          inv;

    atr_if.valid     = 1'b0;
    atr_if.data_byte = 8'h00;
    atr_if.last_byte = 1'b0;
    gap_pct          = 15;
    stall_pct        = 15;
    quiet            = 1'b0;
    bytes_sent       = 0;
    rst_n            = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Lone byte with an unknown TS
    atr_q = '{8'hFF};
    send_atr(1'b0);
    // Bare TS and T0
    atr_q = '{TsDirect, 8'h00};
    send_atr(1'b0);
    // Inverse convention, every first-group byte plus TB2, all-ones values
    atr_q = '{TsInverse, 8'hF2, 8'hFF, 8'hFF, 8'hFF, 8'h2F, 8'hFF, 8'h00, 8'hFF,
              8'h00};
    send_atr(1'b1);
    // Lone group with an FI that has no clock rate
    atr_q = '{TsDirect, 8'h10, 8'h71};
    send_atr(1'b0);
    // Lone group with TB1 above 0x80
    atr_q = '{TsDirect, 8'h20, 8'h81};
    send_atr(1'b0);
    // Final byte while interface bytes are still due
    atr_q = '{TsDirect, 8'hF0, 8'h11};
    send_atr(1'b0);
    // Fewer historical bytes than declared
    atr_q = '{TsDirect, 8'h05, 8'hAA, 8'hBB};
    send_atr(1'b0);
    // Check byte expected but none left
    atr_q = '{TsDirect, 8'h80, 8'h01};
    send_atr(1'b0);
    wait_drained();

    // Random ATRs: mostly well-formed with random content, the rest broken
    while (bytes_sent < 700) begin
      if (bytes_sent >= 600) begin
        quiet = 1'b1;
      end else begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 50;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 50;
        endcase
      end

      atr_q.delete();
      inv = ($urandom_range(0, 3) == 0);
      if (inv) ts = TsInverse;
      else if ($urandom_range(0, 7) == 0) ts = 8'($urandom);
      else ts = TsDirect;
      n_grp  = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
      k_hist = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 15) : $urandom_range(0, 6);
      mask    = 4'($urandom_range(0, 7));
      mask[3] = (n_grp > 0);
      proto   = 4'd0;
      atr_q.push_back(ts);
      atr_q.push_back({mask, k_hist[3:0]});

      // Interface groups, TD chaining to the next while groups remain
      for (int g = 0; g <= n_grp; g++) begin
        if (mask[0]) begin
          ib = 8'($urandom);
          if (g == 0 && $urandom_range(0, 3) != 0) ib[7:4] = 4'($urandom_range(0, 6));
          atr_q.push_back(ib);
        end
        if (mask[1]) begin
          ib = 8'($urandom);
          if (g == 0 && $urandom_range(0, 3) != 0) ib[7] = 1'b0;
          atr_q.push_back(ib);
        end
        if (mask[2]) atr_q.push_back(8'($urandom));
        if (mask[3]) begin
          next_mask    = 4'($urandom_range(0, 7));
          next_mask[3] = (g + 1 < n_grp);
          proto        = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(1, 15));
          atr_q.push_back({next_mask, proto});
          mask = next_mask;
        end
      end
      repeat (k_hist) atr_q.push_back(8'($urandom));
      if (proto != 4'd0) atr_q.push_back(8'($urandom));

      // Break some: cut short, trailing junk, oversized, or pure noise
      case ($urandom_range(0, 19))
        0, 1: begin
          cut = int'($urandom_range(1, atr_q.size()));
          while (atr_q.size() > cut) void'(atr_q.pop_back());
        end
        2, 3: repeat ($urandom_range(1, 3)) atr_q.push_back(8'($urandom));
        4: begin
          target = int'($urandom_range(34, 40));
          while (atr_q.size() < target) atr_q.push_back(8'($urandom));
        end
        5: begin
          atr_q.delete();
          repeat ($urandom_range(1, 6)) atr_q.push_back(8'($urandom));
          inv = 1'b0;
        end
        default: ;
      endcase

      send_atr(inv);
      if (!quiet && $urandom_range(0, 19) == 0) wait_drained();
    end

    // Drain, then let the pipeline settle before the verdict
    @(negedge clk);
    atr_if.valid     = 1'b0;
    atr_if.last_byte = 1'b0;
    waited = 0;
    while (summaries_due != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (summaries_due != 0) $error("%0d summaries never arrived", summaries_due);
    if (mismatches == 0 && summaries_due == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin : watchdog
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
